[hdl/imu_cf_pkg.sv]
// Shared types, constants and the arctangent table for the IMU complementary filter.
package imu_cf_pkg;

    localparam int CordicIterations = 16;
    localparam int AtanTableLen     = 24;
    localparam int CordicSteps      = (CordicIterations < AtanTableLen) ?
                                      CordicIterations : AtanTableLen;
    localparam int QueueDepth       = 2;

    localparam logic [1:0] RegGyroGain    = 2'd0;
    localparam logic [1:0] RegBlendWeight = 2'd1;
    localparam logic [1:0] RegForceLow    = 2'd2;
    localparam logic [1:0] RegForceHigh   = 2'd3;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] angle_x_out;
        logic signed [31:0] angle_y_out;
        logic               accel_blended;
    } t_result;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic               blend;
    } t_job;

    typedef struct packed {
        logic [23:0] gyro_gain;
        logic [16:0] weight;
        logic [16:0] force_low;
        logic [16:0] force_high;
    } t_cfg;

    function automatic logic [21:0] atan_deg(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/imu_cf_if.sv]
// Valid/ready channel interfaces for samples, results and register writes.
interface imu_cf_sample_if;
    logic                   valid;
    logic                   ready;
    imu_cf_pkg::t_sample    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface imu_cf_result_if;
    logic                   valid;
    logic                   ready;
    imu_cf_pkg::t_result    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface imu_cf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

[hdl/imu_complementary_filter.sv]
// Top level of the IMU tilt complementary filter.
// Without blending a request runs the gyro update for both axes; with blending it also runs
// the bit-serial square root, CORDIC and blend for each axis.
// The shared arithmetic unit serves one request at a time; it takes the next one only when idle.
// The two-entry queue takes new requests while the back end works.
// Synchronous active-low reset clears both angles and restores register defaults.
module imu_complementary_filter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    imu_cf_sample_if.sink     s_in,
    imu_cf_result_if.source   m_out,
    imu_cf_cfg_if.sink        s_cfg
);
    imu_cf_pkg::t_cfg r_cfg;
    imu_cf_pkg::t_job job;
    logic q_valid, q_ready;

    assign s_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gyro_gain  <= 24'd15345;
            r_cfg.weight     <= 17'd1311;
            r_cfg.force_low  <= 17'd8192;
            r_cfg.force_high <= 17'd32768;
        end else if (s_cfg.valid) begin
            case (s_cfg.index)
                imu_cf_pkg::RegGyroGain:    r_cfg.gyro_gain  <= s_cfg.wdata;
                imu_cf_pkg::RegBlendWeight: r_cfg.weight     <= s_cfg.wdata[16:0];
                imu_cf_pkg::RegForceLow:    r_cfg.force_low  <= s_cfg.wdata[16:0];
                imu_cf_pkg::RegForceHigh:   r_cfg.force_high <= s_cfg.wdata[16:0];
                default: ;
            endcase
        end
    end

    imu_cf_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_in.valid), .o_ready(s_in.ready), .i_sample(s_in.data),
        .i_force_low(r_cfg.force_low), .i_force_high(r_cfg.force_high),
        .o_valid(q_valid), .i_ready(q_ready), .o_job(job)
    );

    imu_cf_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_job(job), .i_cfg(r_cfg),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_result(m_out.data)
    );
endmodule

[hdl/imu_cf_front.sv]
// Front end: accepts samples, decides blending and feeds a two-entry queue.
module imu_cf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  imu_cf_pkg::t_sample   i_sample,
    input  logic [16:0]           i_force_low,
    input  logic [16:0]           i_force_high,
    output logic                  o_valid,
    input  logic                  i_ready,
    output imu_cf_pkg::t_job      o_job
);
    imu_cf_pkg::t_job r_q [imu_cf_pkg::QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [15:0] ax, ay, az;
    logic [16:0] mag;
    logic push, pop;
    imu_cf_pkg::t_job job;

    always_comb begin
        ax  = i_sample.accel_x[15] ? 16'(-i_sample.accel_x) : i_sample.accel_x;
        ay  = i_sample.accel_y[15] ? 16'(-i_sample.accel_y) : i_sample.accel_y;
        az  = i_sample.accel_z[15] ? 16'(-i_sample.accel_z) : i_sample.accel_z;
        mag = 17'(ax) + 17'(ay) + 17'(az);
        job.accel_x = i_sample.accel_x;
        job.accel_y = i_sample.accel_y;
        job.accel_z = i_sample.accel_z;
        job.rate_x  = i_sample.rate_x;
        job.rate_y  = i_sample.rate_y;
        job.blend   = (mag > i_force_low) && (mag < i_force_high);
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("queue overfilled");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_push_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + 2'd1) else $error("lost request");
`endif
endmodule

[hdl/imu_cf_back.sv]
// Back end: gyro integration, square root, CORDIC and blend, one unit at a time.
module imu_cf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  imu_cf_pkg::t_job     i_job,
    input  imu_cf_pkg::t_cfg     i_cfg,
    output logic                 o_valid,
    input  logic                 i_ready,
    output imu_cf_pkg::t_result  o_result
);
    typedef enum logic [3:0] {
        S_IDLE, S_GMUL, S_GADD, S_SQR, S_SQRT, S_CORD, S_BMUL, S_BADD, S_NEXT, S_OUT
    } t_state;

    t_state r_state;
    imu_cf_pkg::t_job r_job;
    logic r_axis;
    logic signed [31:0] r_ang_x, r_ang_y;
    logic signed [40:0] r_prod;
    logic [33:0] r_rem;
    logic [32:0] r_root;
    logic [33:0] r_n;
    logic [4:0]  r_cnt;
    logic signed [36:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic signed [49:0] r_pa, r_pt;
    logic [16:0] r_w;
    logic r_ovalid;
    imu_cf_pkg::t_result r_res;

    logic signed [31:0] cur_ang;
    logic signed [15:0] cur_rate, cur_a, cur_b, cur_num;
    logic signed [41:0] gsum;
    logic signed [50:0] bsum;
    logic signed [31:0] sat_g, sat_b;
    logic [33:0] trial;
    logic signed [36:0] dx, dy;
    logic [4:0] sidx;

    always_comb begin
        cur_ang  = r_axis ? r_ang_y : r_ang_x;
        cur_rate = r_axis ? r_job.rate_y : r_job.rate_x;
        cur_num  = r_axis ? r_job.accel_x : r_job.accel_y;
        cur_a    = r_job.accel_z;
        cur_b    = r_axis ? r_job.accel_y : r_job.accel_x;
        gsum = 42'(cur_ang) + 42'((r_prod + 41'sd128) >>> 8);
        if (gsum > 42'sd2147483647) sat_g = 32'h7fffffff;
        else if (gsum < -42'sd2147483648) sat_g = 32'h80000000;
        else sat_g = gsum[31:0];
        bsum = 51'(r_pa) + 51'(r_pt) + 51'sd32768;
        bsum = bsum >>> 16;
        if (bsum > 51'sd2147483647) sat_b = 32'h7fffffff;
        else if (bsum < -51'sd2147483648) sat_b = 32'h80000000;
        else sat_b = bsum[31:0];
        trial = r_rem - {r_root[31:0], 2'b01};
        sidx = r_cnt;
        dx = r_cy >>> sidx;
        dy = r_cx >>> sidx;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ang_x  <= 32'sd0;
            r_ang_y  <= 32'sd0;
            r_axis   <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && r_state != S_OUT) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_job   <= i_job;
                        r_axis  <= 1'b0;
                        r_w     <= (i_cfg.weight > 17'd65536) ? 17'd65536 : i_cfg.weight;
                        r_state <= S_GMUL;
                    end
                end
                S_GMUL: begin
                    r_prod  <= 41'(cur_rate) * $signed({1'b0, i_cfg.gyro_gain});
                    r_state <= S_GADD;
                end
                S_GADD: begin
                    if (r_axis) r_ang_y <= sat_g;
                    else        r_ang_x <= sat_g;
                    r_axis  <= ~r_axis;
                    r_state <= r_axis ? (r_job.blend ? S_SQR : S_OUT) : S_GMUL;
                end
                S_SQR: begin
                    r_n     <= 34'(32'(cur_a * cur_a) + 32'(cur_b * cur_b));
                    r_rem   <= 34'd0;
                    r_root  <= 33'd0;
                    r_cnt   <= 5'd26;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    // One result bit per cycle on the 52-bit value n * 2^18.
                    if (!trial[33]) begin
                        r_rem  <= {trial[31:0], r_n[33:32]};
                        r_root <= {r_root[31:0], 1'b1};
                    end else begin
                        r_rem  <= {r_rem[31:0], r_n[33:32]};
                        r_root <= {r_root[31:0], 1'b0};
                    end
                    r_n <= {r_n[31:0], 2'b00};
                    if (r_cnt == 5'd1) begin
                        r_state <= S_CORD;
                    end
                    r_cnt <= r_cnt - 5'd1;
                end
                S_CORD: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd0) begin
                        // First step uses the fresh root and numerator directly.
                        if (cur_num > 16'sd0) begin
                            r_cx <= 37'($signed({4'd0, r_root})) + 37'(cur_num) * 37'sd256;
                            r_cy <= 37'(cur_num) * 37'sd256 - 37'($signed({4'd0, r_root}));
                            r_cz <= 32'($signed({1'b0, imu_cf_pkg::atan_deg(5'd0)}));
                        end else begin
                            r_cx <= 37'($signed({4'd0, r_root})) - 37'(cur_num) * 37'sd256;
                            r_cy <= 37'(cur_num) * 37'sd256 + 37'($signed({4'd0, r_root}));
                            r_cz <= -32'($signed({1'b0, imu_cf_pkg::atan_deg(5'd0)}));
                        end
                    end else begin
                        if (r_cy > 37'sd0) begin
                            r_cx <= r_cx + dx;
                            r_cy <= r_cy - dy;
                            r_cz <= r_cz + 32'($signed({1'b0, imu_cf_pkg::atan_deg(sidx)}));
                        end else begin
                            r_cx <= r_cx - dx;
                            r_cy <= r_cy + dy;
                            r_cz <= r_cz - 32'($signed({1'b0, imu_cf_pkg::atan_deg(sidx)}));
                        end
                    end
                    if (r_cnt == 5'(imu_cf_pkg::CordicSteps - 1)) r_state <= S_BMUL;
                end
                S_BMUL: begin
                    r_pa    <= 50'(cur_ang) * $signed({1'b0, 18'(17'd65536 - r_w)});
                    r_pt    <= 50'(r_cz) * $signed({1'b0, r_w});
                    r_state <= S_BADD;
                end
                S_BADD: begin
                    if (r_axis) r_ang_y <= sat_b;
                    else        r_ang_x <= sat_b;
                    r_axis  <= ~r_axis;
                    r_state <= r_axis ? S_OUT : S_SQR;
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_res.angle_x_out   <= r_ang_x;
                        r_res.angle_y_out   <= r_ang_y;
                        r_res.accel_blended <= r_job.blend;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid) else $error("result dropped");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_state == S_GMUL) else $error("request not started");
    a_axis_sqr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> !r_axis) else $error("axis out of step");
`endif
endmodule
